[rtl/core/tcce_pkg.sv]
package tcce_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = ROWS * COLUMNS;

	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int MADDR_W = $clog2(CELLS);
	localparam int POS_W = 11;
	localparam int CELL_W = 16;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] RESET_COLOR = 8'h1F;
	localparam logic [CELL_W-1:0] BLANK_RESET = {RESET_COLOR, CHAR_SPACE};

	localparam logic REG_TEXT_COLOR = 1'b0;

	typedef enum logic [1:0] {
		OP_PUT = 2'd0,
		OP_BACKSPACE = 2'd1,
		OP_READ = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef struct packed {
		logic en;
		logic [MADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} mem_wr_t;

endpackage

[rtl/core/tcce_screen.sv]
module tcce_screen import tcce_pkg::*; (
	input logic clk,
	input mem_wr_t wr,
	input logic [MADDR_W-1:0] rd_addr,
	output logic [CELL_W-1:0] rd_data_q
);

	logic [CELL_W-1:0] screen_q [CELLS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			screen_q[wr.addr] <= wr.data;
		end
		rd_data_q <= screen_q[rd_addr];
	end

endmodule

[rtl/core/text_console_cursor_engine_core.sv]
// text console cursor engine: an 80x25 screen of 16-bit cells plus a cursor
// input channel (in_valid/in_ready) carries opcode, char_code, cell_address;
// output channel (out_valid/out_ready) returns cursor_position, did_scroll and
// cell_value, one result item for every input item, in order
// text_color is written over apb at byte address 0; the user writes it only
// while idle, the block does not enforce this; each item's cell write or read
// on the screen ram is issued in idle, and its result is formed in finish
// a put or newline that leaves the last row scrolls the screen: the single
// write port of the screen ram moves one cell a cycle, and no new item is
// taken meanwhile
// after reset the screen is cleared to blanks in color 0x1F, one cell a cycle,
// over all ROWS*COLUMNS cells; in_ready stays low during that pass, apb
// writes are taken as usual
// one result can wait in the output register and one more in a holding stage;
// when both are full in_ready drops until out_ready takes a result
module text_console_cursor_engine_core import tcce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic [7:0] char_code,
	input logic [10:0] cell_address,
	output logic out_valid,
	input logic out_ready,
	output logic [10:0] cursor_position,
	output logic did_scroll,
	output logic [15:0] cell_value
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic [MADDR_W-1:0] cnt_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [7:0] color_q;
	logic scroll_q;
	logic rd_hit_q;

	logic copy_valid_s1;
	logic copy_fill_s1;
	logic [MADDR_W-1:0] copy_addr_s1;

	logic pend_q;
	logic [POS_W-1:0] pend_pos_q;
	logic pend_scroll_q;
	logic [CELL_W-1:0] pend_value_q;

	logic out_valid_q;
	logic [POS_W-1:0] out_pos_q;
	logic out_scroll_q;
	logic [CELL_W-1:0] out_value_q;

	logic accept;
	logic cfg_wr;
	op_t op;
	logic [ROW_W-1:0] nrow;
	logic [COL_W-1:0] ncol;
	logic nscroll;
	logic adv;
	logic wr_acc;
	logic [MADDR_W-1:0] wr_acc_addr;
	logic [CELL_W-1:0] wr_acc_data;
	logic [MADDR_W-1:0] cur_pos;
	logic [MADDR_W-1:0] bs_pos;
	logic [MADDR_W:0] src_addr;
	logic rd_in_range;
	logic [MADDR_W-1:0] rd_addr;
	logic [CELL_W-1:0] rd_data;
	logic [CELL_W-1:0] res_value;
	logic out_free;
	mem_wr_t wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, color_q} : 32'd0;

	assign in_ready = (state_q == ST_IDLE) && !pend_q;
	assign accept = in_valid & in_ready;
	assign op = op_t'(opcode);
	assign out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign cursor_position = out_pos_q;
	assign did_scroll = out_scroll_q;
	assign cell_value = out_value_q;

	assign cur_pos = MADDR_W'(row_q) * MADDR_W'(COLUMNS) + MADDR_W'(col_q);

	// next cursor and the cell touched by this item
	always_comb begin
		nrow = row_q;
		ncol = col_q;
		nscroll = 1'b0;
		adv = 1'b0;
		wr_acc = 1'b0;
		wr_acc_data = {color_q, CHAR_SPACE};
		unique case (op)
			OP_PUT: begin
				if (char_code == CHAR_NEWLINE) begin
					adv = 1'b1;
				end else begin
					wr_acc = 1'b1;
					wr_acc_data = {color_q, char_code};
					if (col_q == COL_W'(COLUMNS - 1)) begin
						adv = 1'b1;
					end else begin
						ncol = col_q + 1'b1;
					end
				end
			end
			OP_BACKSPACE: begin
				wr_acc = 1'b1;
				if (col_q == '0) begin
					ncol = COL_W'(COLUMNS - 1);
					if (row_q != '0) begin
						nrow = row_q - 1'b1;
					end
				end else begin
					ncol = col_q - 1'b1;
				end
			end
			OP_READ, OP_NOP: begin
			end
		endcase
		if (adv) begin
			ncol = '0;
			if (row_q == ROW_W'(ROWS - 1)) begin
				nscroll = 1'b1;
			end else begin
				nrow = row_q + 1'b1;
			end
		end
	end

	assign bs_pos = MADDR_W'(nrow) * MADDR_W'(COLUMNS) + MADDR_W'(ncol);
	assign wr_acc_addr = (op == OP_BACKSPACE) ? bs_pos : cur_pos;

	// scroll reads one row ahead of the cell it rewrites
	assign src_addr = {1'b0, cnt_q} + (MADDR_W + 1)'(COLUMNS);

	always_comb begin
		if (state_q == ST_SCROLL) begin
			rd_in_range = int'(src_addr) < CELLS;
			rd_addr = rd_in_range ? src_addr[MADDR_W-1:0] : '0;
		end else begin
			rd_in_range = int'(cell_address) < CELLS;
			rd_addr = rd_in_range ? MADDR_W'(cell_address) : '0;
		end
	end

	always_comb begin
		wr.en = 1'b0;
		wr.addr = wr_acc_addr;
		wr.data = wr_acc_data;
		priority if (state_q == ST_CLEAR) begin
			wr.en = 1'b1;
			wr.addr = cnt_q;
			wr.data = BLANK_RESET;
		end else if (copy_valid_s1) begin
			wr.en = 1'b1;
			wr.addr = copy_addr_s1;
			wr.data = copy_fill_s1 ? {color_q, CHAR_SPACE} : rd_data;
		end else if (accept && wr_acc) begin
			wr.en = 1'b1;
		end else begin
			wr.en = 1'b0;
		end
	end

	tcce_screen u_screen (
		.clk(clk),
		.wr(wr),
		.rd_addr(rd_addr),
		.rd_data_q(rd_data)
	);

	assign res_value = rd_hit_q ? rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			color_q <= RESET_COLOR;
			scroll_q <= 1'b0;
			rd_hit_q <= 1'b0;
			copy_valid_s1 <= 1'b0;
			copy_fill_s1 <= 1'b0;
			copy_addr_s1 <= '0;
			pend_q <= 1'b0;
			pend_pos_q <= '0;
			pend_scroll_q <= 1'b0;
			pend_value_q <= '0;
			out_valid_q <= 1'b0;
			out_pos_q <= '0;
			out_scroll_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (cfg_wr && paddr[2] == REG_TEXT_COLOR) begin
				color_q <= pwdata[7:0];
			end

			// a held result and a finishing item never meet
			if (pend_q && out_free) begin
				out_valid_q <= 1'b1;
				out_pos_q <= pend_pos_q;
				out_scroll_q <= pend_scroll_q;
				out_value_q <= pend_value_q;
				pend_q <= 1'b0;
			end else if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
				out_pos_q <= POS_W'(cur_pos);
				out_scroll_q <= scroll_q;
				out_value_q <= res_value;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			copy_valid_s1 <= (state_q == ST_SCROLL);

			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= (cnt_q == MADDR_W'(CELLS - 1)) ? '0 : cnt_q + 1'b1;
					if (cnt_q == MADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						row_q <= nrow;
						col_q <= ncol;
						scroll_q <= nscroll;
						rd_hit_q <= (op == OP_READ) && rd_in_range;
						cnt_q <= '0;
						state_q <= nscroll ? ST_SCROLL : ST_FINISH;
					end
				end
				ST_SCROLL: begin
					copy_addr_s1 <= cnt_q;
					copy_fill_s1 <= cnt_q >= MADDR_W'(CELLS - COLUMNS);
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MADDR_W'(CELLS - 1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_free) begin
						pend_q <= 1'b1;
						pend_pos_q <= POS_W'(cur_pos);
						pend_scroll_q <= scroll_q;
						pend_value_q <= res_value;
					end
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sim/text_console_cursor_engine_core_tb.sv]
module text_console_cursor_engine_core_tb;
	import tcce_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_TEXT_COLOR = 3'(4 * REG_TEXT_COLOR);
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		op_t op;
		logic [7:0] ch;
		logic [10:0] addr;
	} console_op_t;

	typedef struct {
		logic [10:0] pos;
		logic scrolled;
		logic [15:0] cell_val;
	} console_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = OP_NOP;
	logic [7:0] char_code = '0;
	logic [10:0] cell_address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [10:0] cursor_position;
	logic did_scroll;
	logic [15:0] cell_value;

	text_console_cursor_engine_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.char_code(char_code),
		.cell_address(cell_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_position(cursor_position),
		.did_scroll(did_scroll),
		.cell_value(cell_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// screen and cursor as the block should hold them
	logic [15:0] screen [0:CELLS-1];
	int cur_row;
	int cur_col;
	logic [7:0] color;

	console_op_t pending_ops[$];
	console_result_t console_results[$];
	int mismatches = 0;
	int cycles = 0;

	function automatic logic advance_row();
		cur_row++;
		if (cur_row < ROWS)
			return 1'b0;
		cur_row = ROWS - 1;
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (int j = 0; j < COLUMNS; j++)
			screen[(ROWS - 1) * COLUMNS + j] = {color, CHAR_SPACE};
		return 1'b1;
	endfunction

	function automatic console_result_t console_step(input console_op_t it);
		console_result_t r;
		r.scrolled = 1'b0;
		r.cell_val = '0;
		case (it.op)
			OP_PUT: begin
				if (it.ch == CHAR_NEWLINE) begin
					cur_col = 0;
					r.scrolled = advance_row();
				end else begin
					screen[cur_row * COLUMNS + cur_col] = {color, it.ch};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						r.scrolled = advance_row();
					end
				end
			end
			OP_BACKSPACE: begin
				if (cur_col == 0) begin
					cur_col = COLUMNS - 1;
					if (cur_row > 0)
						cur_row--;
				end else begin
					cur_col--;
				end
				screen[cur_row * COLUMNS + cur_col] = {color, CHAR_SPACE};
			end
			OP_READ: begin
				if (it.addr < CELLS)
					r.cell_val = screen[it.addr];
			end
			default: ;
		endcase
		r.pos = 11'(cur_row * COLUMNS + cur_col);
		return r;
	endfunction

	function automatic console_op_t random_op();
		console_op_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.ch = 8'($urandom_range(0, 255));
		it.addr = 11'($urandom_range(0, 2047));
		if (pick < 10) begin
			it.op = OP_PUT;
			it.ch = CHAR_NEWLINE;
		end else if (pick < 55) begin
			it.op = OP_PUT;
		end else if (pick < 70) begin
			it.op = OP_BACKSPACE;
		end else if (pick < 94) begin
			it.op = OP_READ;
			// lean on the bottom rows where writes and scrolls land
			if (pick < 82)
				it.addr = 11'($urandom_range(CELLS - 4 * COLUMNS, CELLS - 1));
			else if (pick < 92)
				it.addr = 11'($urandom_range(0, CELLS - 1));
		end else begin
			it.op = OP_NOP;
		end
		return it;
	endfunction

	task automatic push_op(input op_t op, input logic [7:0] ch, input logic [10:0] addr);
		console_op_t it;
		it.op = op;
		it.ch = ch;
		it.addr = addr;
		pending_ops.push_back(it);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [7:0] val);
		logic [31:0] data;
		// upper bits carry junk, only the low byte counts
		data = {24'($urandom_range(0, 32'hFFFFFF)), val};
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_TEXT_COLOR)
			color = val;
	endtask

	// look between edges so a just popped item is seen as valid
	task automatic wait_idle();
		while (pending_ops.size() > 0 || in_valid || console_results.size() > 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		repeat (count) pending_ops.push_back(random_op());
		wait_idle();
	endtask

	// sender: bursts of random length separated by random gaps
	int tx_burst = 0;
	int tx_gap = 0;

	always @(posedge clk) begin
		console_op_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_burst <= 0;
			tx_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (tx_gap > 0 || pending_ops.size() == 0) begin
				in_valid <= 1'b0;
				if (tx_gap > 0)
					tx_gap <= tx_gap - 1;
			end else begin
				it = pending_ops.pop_front();
				in_valid <= 1'b1;
				opcode <= it.op;
				char_code <= it.ch;
				cell_address <= it.addr;
				if (tx_burst == 0) begin
					tx_burst <= $urandom_range(1, 40);
					tx_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					tx_burst <= tx_burst - 1;
				end
			end
		end
	end

	// receiver: windows of always ready, run-length stalls or per-cycle coin flips
	int rx_window = 0;
	int rx_mode = 0;
	int rx_run = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_window <= 0;
			rx_mode <= 0;
			rx_run <= 0;
		end else begin
			if (rx_window == 0) begin
				rx_window <= $urandom_range(50, 300);
				rx_mode <= $urandom_range(0, 2);
			end else begin
				rx_window <= rx_window - 1;
			end
			if (rx_mode == 0) begin
				out_ready <= 1'b1;
			end else if (rx_mode == 1) begin
				if (rx_run > 0) begin
					rx_run <= rx_run - 1;
				end else begin
					out_ready <= !out_ready;
					rx_run <= out_ready ? $urandom_range(0, 15) : $urandom_range(0, 20);
				end
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// monitor: check the result first, then predict the item taken on this edge
	always @(posedge clk) begin
		console_result_t want;
		console_op_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (console_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: result with none pending: pos %0d scroll %0b cell %h",
							$realtime, cursor_position, did_scroll, cell_value);
				end else begin
					want = console_results.pop_front();
					if (cursor_position !== want.pos || did_scroll !== want.scrolled ||
							cell_value !== want.cell_val) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("%0t: mismatch pos %0d/%0d scroll %0b/%0b cell %h/%h",
								$realtime, want.pos, cursor_position, want.scrolled,
								did_scroll, want.cell_val, cell_value);
					end
				end
			end
			if (in_valid && in_ready) begin
				seen.op = op_t'(opcode);
				seen.ch = char_code;
				seen.addr = cell_address;
				console_results.push_back(console_step(seen));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		color = RESET_COLOR;
		cur_row = 0;
		cur_col = 0;
		for (int i = 0; i < CELLS; i++)
			screen[i] = BLANK_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset contents, address limits, no-op opcode, wrap cases
		push_op(OP_READ, 8'h00, 11'd0);
		push_op(OP_READ, 8'hFF, 11'(CELLS - 1));
		push_op(OP_READ, 8'h00, 11'(CELLS));
		push_op(OP_READ, 8'h00, 11'h7FF);
		push_op(OP_NOP, 8'hFF, 11'h7FF);
		push_op(OP_BACKSPACE, 8'hFF, 11'h7FF);
		push_op(OP_READ, 8'h00, 11'(COLUMNS - 1));
		push_op(OP_PUT, 8'hFF, 11'd0);
		push_op(OP_BACKSPACE, 8'h00, 11'd0);
		push_op(OP_PUT, 8'h00, 11'h7FF);
		push_op(OP_READ, 8'h00, 11'(COLUMNS - 1));
		push_op(OP_PUT, CHAR_NEWLINE, 11'd0);
		push_op(OP_PUT, 8'h41, 11'd0);
		push_op(OP_READ, 8'h00, 11'(2 * COLUMNS));
		push_op(OP_BACKSPACE, 8'h00, 11'd0);
		push_op(OP_READ, 8'h00, 11'(2 * COLUMNS));
		push_op(OP_NOP, 8'h00, 11'd0);
		wait_idle();

		apb_write(ADDR_TEXT_COLOR, 8'h00);
		run_random(300);
		apb_write(ADDR_UNUSED, 8'($urandom_range(0, 255)));
		apb_write(ADDR_TEXT_COLOR, 8'hFF);
		run_random(300);
		apb_write(ADDR_TEXT_COLOR, 8'($urandom_range(0, 255)));
		run_random(300);
		apb_write(ADDR_TEXT_COLOR, 8'($urandom_range(0, 255)));
		run_random(250);

		if (mismatches == 0 && console_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/tcce_pkg.sv
rtl/core/tcce_screen.sv
rtl/core/text_console_cursor_engine_core.sv
sim/text_console_cursor_engine_core_tb.sv
